// File: rtl/core/isotp_rx_pkg.sv
package isotp_rx_pkg;

	// Default store depth in bytes
	localparam int MAX_PDU_DEF = 256;

	// Protocol control nibble (upper half of byte 0)
	localparam logic [3:0] PCI_SF = 4'h0;
	localparam logic [3:0] PCI_FF = 4'h1;
	localparam logic [3:0] PCI_CF = 4'h2;
	localparam logic [3:0] PCI_FC = 4'h3;

	// Result kinds
	localparam logic [1:0] KIND_CHUNK = 2'd0;
	localparam logic [1:0] KIND_FC    = 2'd1;
	localparam logic [1:0] KIND_TX    = 2'd2;
	localparam logic [1:0] KIND_OVR   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_PHYS_ID = 2'd1;
	localparam logic [1:0] REG_FUNC_ID = 2'd2;

	localparam logic [28:0] PHYS_ID_RST = 29'd2016;
	localparam logic [28:0] FUNC_ID_RST = 29'd2015;

	localparam logic [7:0] FC_CTS_BYTE = 8'h30;
	localparam logic [3:0] FC_COUNT    = 4'd3;
	localparam logic [3:0] SF_MAX_LEN  = 4'd7;
	localparam logic [3:0] CAN_MAX_DLC = 4'd8;
	localparam logic [2:0] FF_BYTES    = 3'd6;
	localparam logic [2:0] CF_BYTES    = 3'd7;

	typedef struct packed {
		logic            hit;
		logic [3:0]      dlc;
		logic [7:0][7:0] data;
		logic            tx_wait;
	} rx_frame_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [7:0][7:0] data;
		logic [3:0]      count;
		logic [11:0]     plen;
		logic            last;
	} rx_result_t;

endpackage

// File: rtl/core/isotp_rx_ram.sv
module isotp_rx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/isotp_rx_ctrl.sv
module isotp_rx_ctrl #(
	parameter int MAX_PDU = isotp_rx_pkg::MAX_PDU_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  isotp_rx_pkg::rx_frame_t    frame,
	input  logic                       frame_valid,
	output logic                       frame_ready,
	output isotp_rx_pkg::rx_result_t   result,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic                       mem_we,
	output logic [$clog2(MAX_PDU)-1:0] mem_waddr,
	output logic [7:0]                 mem_wdata,
	output logic                       mem_re,
	output logic [$clog2(MAX_PDU)-1:0] mem_raddr,
	input  logic [7:0]                 mem_rdata
);

	import isotp_rx_pkg::*;

	localparam int AW = $clog2(MAX_PDU);
	localparam int HW = $clog2(MAX_PDU + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_EMIT, ST_CALC, ST_WRITE, ST_DRAIN, ST_FIN, ST_CHUNK
	} state_t;

	typedef enum logic [2:0] {
		ACT_TX, ACT_SF, ACT_OVR, ACT_FC, ACT_CF
	} act_t;

	state_t          state_q;
	act_t            act_q;
	logic [7:0][7:0] byte_q;
	logic [7:0][7:0] chunk_q;
	logic [HW-1:0]   exp_q;
	logic [HW-1:0]   held_q;
	logic [HW-1:0]   plen_q;
	logic [3:0]      nseq_q;
	logic            done_q;
	logic [AW-1:0]   wr_addr_q;
	logic [2:0]      wr_left_q;
	logic [2:0]      src_q;
	logic [AW-1:0]   rd_addr_q;
	logic            rd_v_s1;
	logic [2:0]      rd_idx_s1;
	rx_result_t      res_q;
	logic            res_valid_q;

	logic            accept;
	logic            out_free;
	logic            res_load;
	logic [3:0]      pci;
	logic [3:0]      low;
	logic [11:0]     ff_len;
	logic            sf_bad;
	logic [3:0]      sf_len;
	logic [HW-1:0]   diff;
	logic [2:0]      take;
	logic [HW-1:0]   new_held;
	logic            rd_last;
	logic            chunk_end;
	rx_result_t      res_next;

	assign frame_ready  = (state_q == ST_IDLE);
	assign accept       = frame_valid && frame_ready;
	assign out_free     = !res_valid_q || result_ready;
	assign res_load     = ((state_q == ST_EMIT) || (state_q == ST_CHUNK)) && out_free;
	assign result       = res_q;
	assign result_valid = res_valid_q;

	assign pci    = frame.data[0][7:4];
	assign low    = frame.data[0][3:0];
	assign ff_len = {low, frame.data[1]};
	assign sf_bad = (low == 4'd0) || (low > SF_MAX_LEN) || (low > frame.dlc - 4'd1);
	assign sf_len = byte_q[0][3:0];

	assign diff     = (exp_q > held_q) ? exp_q - held_q : '0;
	assign take     = (diff > HW'(CF_BYTES)) ? CF_BYTES : diff[2:0];
	assign new_held = held_q + HW'(take);

	assign rd_last   = ((HW'(rd_addr_q) + HW'(1)) == plen_q);
	assign chunk_end = (rd_addr_q[2:0] == 3'd7) || rd_last;

	// Store writes and drain reads never overlap: one frame is worked at a time
	assign mem_we    = (state_q == ST_WRITE) && (wr_left_q != 3'd0);
	assign mem_waddr = wr_addr_q;
	assign mem_wdata = byte_q[src_q];
	assign mem_re    = (state_q == ST_DRAIN);
	assign mem_raddr = rd_addr_q;

	always_comb begin
		res_next      = '0;
		res_next.last = 1'b1;
		case (state_q)
			ST_CHUNK: begin
				res_next.kind = KIND_CHUNK;
				for (int i = 0; i < 8; i++) begin
					res_next.data[i] = (3'(i) <= rd_addr_q[2:0]) ? chunk_q[i] : 8'd0;
				end
				res_next.count = {1'b0, rd_addr_q[2:0]} + 4'd1;
				res_next.plen  = 12'(plen_q);
				res_next.last  = rd_last;
			end
			default: begin
				case (act_q)
					ACT_TX: res_next.kind = KIND_TX;
					ACT_SF: begin
						res_next.kind = KIND_CHUNK;
						for (int i = 0; i < 7; i++) begin
							res_next.data[i] = (4'(i) < sf_len) ? byte_q[i + 1] : 8'd0;
						end
						res_next.count = sf_len;
						res_next.plen  = {8'd0, sf_len};
					end
					ACT_OVR: begin
						res_next.kind = KIND_OVR;
						res_next.plen = {byte_q[0][3:0], byte_q[1]};
					end
					ACT_FC: begin
						res_next.kind    = KIND_FC;
						res_next.data[0] = FC_CTS_BYTE;
						res_next.count   = FC_COUNT;
					end
					default: ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_q       <= ACT_TX;
			byte_q      <= '0;
			chunk_q     <= '0;
			exp_q       <= '0;
			held_q      <= '0;
			plen_q      <= '0;
			nseq_q      <= '0;
			done_q      <= 1'b0;
			wr_addr_q   <= '0;
			wr_left_q   <= '0;
			src_q       <= '0;
			rd_addr_q   <= '0;
			rd_v_s1     <= 1'b0;
			rd_idx_s1   <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rd_v_s1   <= mem_re;
			rd_idx_s1 <= rd_addr_q[2:0];
			if (rd_v_s1) begin
				chunk_q[rd_idx_s1] <= mem_rdata;
			end
			if (res_load) begin
				res_q       <= res_next;
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && frame.hit) begin
						byte_q <= frame.data;
						if (frame.tx_wait && pci == PCI_FC) begin
							act_q   <= ACT_TX;
							state_q <= ST_EMIT;
						end else begin
							case (pci)
								PCI_SF: begin
									if (!sf_bad) begin
										act_q   <= ACT_SF;
										state_q <= ST_EMIT;
									end
								end
								PCI_FF: begin
									if (ff_len > 12'(MAX_PDU)) begin
										exp_q   <= '0;
										held_q  <= '0;
										act_q   <= ACT_OVR;
										state_q <= ST_EMIT;
									end else begin
										exp_q     <= ff_len[HW-1:0];
										held_q    <= HW'(FF_BYTES);
										nseq_q    <= 4'd1;
										wr_addr_q <= '0;
										src_q     <= 3'd2;
										wr_left_q <= FF_BYTES;
										act_q     <= ACT_FC;
										state_q   <= ST_WRITE;
									end
								end
								PCI_CF: begin
									if (low == nseq_q) begin
										nseq_q  <= nseq_q + 4'd1;
										act_q   <= ACT_CF;
										state_q <= ST_CALC;
									end else begin
										// drop the reassembly, keep the sequence counter
										exp_q  <= '0;
										held_q <= '0;
									end
								end
								default: ;
							endcase
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CALC: begin
					held_q    <= new_held;
					wr_addr_q <= held_q[AW-1:0];
					src_q     <= 3'd1;
					wr_left_q <= take;
					done_q    <= (new_held >= exp_q);
					state_q   <= ST_WRITE;
				end
				ST_WRITE: begin
					if (wr_left_q != 3'd0) begin
						wr_addr_q <= wr_addr_q + AW'(1);
						src_q     <= src_q + 3'd1;
						wr_left_q <= wr_left_q - 3'd1;
					end else if (act_q == ACT_FC) begin
						state_q <= ST_EMIT;
					end else if (done_q) begin
						plen_q    <= exp_q;
						exp_q     <= '0;
						held_q    <= '0;
						rd_addr_q <= '0;
						state_q   <= (exp_q != '0) ? ST_DRAIN : ST_IDLE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRAIN: begin
					if (chunk_end) begin
						state_q <= ST_FIN;
					end else begin
						rd_addr_q <= rd_addr_q + AW'(1);
					end
				end
				ST_FIN: state_q <= ST_CHUNK;
				ST_CHUNK: begin
					if (out_free) begin
						if (rd_last) begin
							state_q <= ST_IDLE;
						end else begin
							rd_addr_q <= rd_addr_q + AW'(1);
							state_q   <= ST_DRAIN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/isotp_receive_reassembler.sv
// ISO-TP receive reassembler: one CAN frame per beat in, results out.
// Single, flow-control and oversize results load the output register from the emit state
// once it is free; a first frame first makes six byte writes into the PDU store, and a
// consecutive frame up to seven. One frame is worked at a time; a completed PDU drains from
// the byte-wide store through its single read port in chunks of up to eight bytes.
// Reset clears the registers and reassembly state; the PDU store keeps contents, needs no clearing.
module isotp_receive_reassembler #(
	parameter int MAX_PDU = isotp_rx_pkg::MAX_PDU_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [28:0] cfg_data,
	// received frame channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [28:0] frame_id,
	input  logic [3:0]  frame_len,
	input  logic [7:0]  byte_0,
	input  logic [7:0]  byte_1,
	input  logic [7:0]  byte_2,
	input  logic [7:0]  byte_3,
	input  logic [7:0]  byte_4,
	input  logic [7:0]  byte_5,
	input  logic [7:0]  byte_6,
	input  logic [7:0]  byte_7,
	input  logic        tx_waiting,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_0,
	output logic [7:0]  out_1,
	output logic [7:0]  out_2,
	output logic [7:0]  out_3,
	output logic [7:0]  out_4,
	output logic [7:0]  out_5,
	output logic [7:0]  out_6,
	output logic [7:0]  out_7,
	output logic [3:0]  valid_count,
	output logic [11:0] pdu_length,
	output logic        last
);

	import isotp_rx_pkg::*;

	localparam int AW = $clog2(MAX_PDU);

	logic          enable_q;
	logic [28:0]   phys_id_q;
	logic [28:0]   func_id_q;
	rx_frame_t     frame;
	rx_result_t    result;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	// Configuration beats are always accepted, so the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			phys_id_q <= PHYS_ID_RST;
			func_id_q <= FUNC_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_PHYS_ID: phys_id_q <= cfg_data;
				REG_FUNC_ID: func_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Address filter: a frame counts only when enabled, addressed to us and not empty.
	// A data length code above eight counts as eight.
	always_comb begin
		frame.hit     = enable_q && (frame_id == phys_id_q || frame_id == func_id_q)
		                && (frame_len != 4'd0);
		frame.dlc     = (frame_len > CAN_MAX_DLC) ? CAN_MAX_DLC : frame_len;
		frame.data[0] = byte_0;
		frame.data[1] = byte_1;
		frame.data[2] = byte_2;
		frame.data[3] = byte_3;
		frame.data[4] = byte_4;
		frame.data[5] = byte_5;
		frame.data[6] = byte_6;
		frame.data[7] = byte_7;
		frame.tx_wait = tx_waiting;
	end

	// Sequencer: decode the frame, write payload bytes, drain finished PDUs and
	// hold the output register, which lets a new frame in while a result waits.
	isotp_rx_ctrl #(
		.MAX_PDU (MAX_PDU)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame),
		.frame_valid  (in_valid),
		.frame_ready  (in_ready),
		.result       (result),
		.result_valid (out_valid),
		.result_ready (out_ready),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	// Byte-wide PDU store; only bytes written since the last first frame are read back.
	isotp_rx_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PDU)
	) u_pdu_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign kind        = result.kind;
	assign out_0       = result.data[0];
	assign out_1       = result.data[1];
	assign out_2       = result.data[2];
	assign out_3       = result.data[3];
	assign out_4       = result.data[4];
	assign out_5       = result.data[5];
	assign out_6       = result.data[6];
	assign out_7       = result.data[7];
	assign valid_count = result.count;
	assign pdu_length  = result.plen;
	assign last        = result.last;

endmodule
